@@ hw/rtl/rgbhsv_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared constants, payload types and divider cell data for the RGB to HSV
// converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int CHANNEL_BITS      = 8;
  localparam int HUE_FRACTION_BITS = 4;
  localparam int HUE_BITS          = 13;

  localparam int CHAN_MAX    = (1 << CHANNEL_BITS) - 1;
  localparam int HUE_SECTOR  = 60 << HUE_FRACTION_BITS;
  localparam int HUE_FULL    = 6 * HUE_SECTOR;
  localparam int HUE_Q_BITS  = $clog2(HUE_SECTOR + 1);
  localparam int QUO_BITS    = (CHANNEL_BITS > HUE_Q_BITS) ? CHANNEL_BITS : HUE_Q_BITS;
  localparam int NUM_BITS    = CHANNEL_BITS + QUO_BITS;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;
    logic                    achromatic;
  } hsv_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] sat_rem;
    logic [QUO_BITS-1:0]     sat_num;
    logic [QUO_BITS-1:0]     sat_quo;
    logic [CHANNEL_BITS-1:0] sat_div;
    logic [CHANNEL_BITS-1:0] hue_rem;
    logic [QUO_BITS-1:0]     hue_num;
    logic [QUO_BITS-1:0]     hue_quo;
    logic [CHANNEL_BITS-1:0] hue_div;
    logic                    neg;
    sector_t                 sector;
    logic [CHANNEL_BITS-1:0] bright;
    logic                    achrom;
  } cell_data_t;

endpackage

@@ hw/rtl/rgbhsv_prep.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_prep
// Two front stages: max/min, sector and channel difference, then the scaled
// numerators that seed the divider chain.
// ----------------------------------------------------------------------------
module rgbhsv_prep (
  input  logic                   clk,
  input  logic                   en_a,
  input  logic                   en_b,
  input  rgbhsv_pkg::pixel_t     pix,
  output rgbhsv_pkg::cell_data_t seed
);

  localparam int CB = rgbhsv_pkg::CHANNEL_BITS;
  localparam int QB = rgbhsv_pkg::QUO_BITS;
  localparam int NB = rgbhsv_pkg::NUM_BITS;

  logic [CB-1:0]       mx, mn, pa, pb;
  rgbhsv_pkg::sector_t sector;

  logic [CB-1:0]       bright_r, delta_r, absdiff_r;
  logic                neg_r;
  rgbhsv_pkg::sector_t sector_r;

  rgbhsv_pkg::cell_data_t seed_r, seed_nxt;
  logic [NB-1:0]          sat_prod, hue_prod;

  always_comb begin
    mx = pix.red;
    mn = pix.red;
    if (pix.green > mx) mx = pix.green;
    if (pix.blue > mx) mx = pix.blue;
    if (pix.green < mn) mn = pix.green;
    if (pix.blue < mn) mn = pix.blue;
    if (mx == pix.red) begin
      sector = rgbhsv_pkg::SEC_RED;
      pa     = pix.green;
      pb     = pix.blue;
    end else if (mx == pix.green) begin
      sector = rgbhsv_pkg::SEC_GREEN;
      pa     = pix.blue;
      pb     = pix.red;
    end else begin
      sector = rgbhsv_pkg::SEC_BLUE;
      pa     = pix.red;
      pb     = pix.green;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      bright_r  <= mx;
      delta_r   <= mx - mn;
      absdiff_r <= (pa >= pb) ? (pa - pb) : (pb - pa);
      neg_r     <= (pa < pb);
      sector_r  <= sector;
    end
  end

  // scaled numerators, top part goes straight into the partial remainder
  always_comb begin
    sat_prod = NB'(rgbhsv_pkg::CHAN_MAX) * NB'(delta_r);
    hue_prod = NB'(rgbhsv_pkg::HUE_SECTOR) * NB'(absdiff_r);
    seed_nxt         = '0;
    seed_nxt.sat_rem = sat_prod[NB-1:QB];
    seed_nxt.sat_num = sat_prod[QB-1:0];
    seed_nxt.sat_quo = '0;
    seed_nxt.sat_div = bright_r;
    seed_nxt.hue_rem = hue_prod[NB-1:QB];
    seed_nxt.hue_num = hue_prod[QB-1:0];
    seed_nxt.hue_quo = '0;
    seed_nxt.hue_div = delta_r;
    seed_nxt.neg     = neg_r;
    seed_nxt.sector  = sector_r;
    seed_nxt.bright  = bright_r;
    seed_nxt.achrom  = (delta_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      seed_r <= seed_nxt;
    end
  end

  assign seed = seed_r;

endmodule

@@ hw/rtl/rgbhsv_cell.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_cell
// One restoring division step for the saturation and hue lanes, registered.
// ----------------------------------------------------------------------------
module rgbhsv_cell (
  input  logic                   clk,
  input  logic                   en,
  input  rgbhsv_pkg::cell_data_t d_in,
  output rgbhsv_pkg::cell_data_t d_out
);

  localparam int CB = rgbhsv_pkg::CHANNEL_BITS;
  localparam int QB = rgbhsv_pkg::QUO_BITS;

  logic [CB:0]            sat_trial, sat_sub, hue_trial, hue_sub;
  logic                   sat_ge, hue_ge;
  rgbhsv_pkg::cell_data_t d_r, d_nxt;

  always_comb begin
    sat_trial = {d_in.sat_rem, d_in.sat_num[QB-1]};
    sat_sub   = sat_trial - {1'b0, d_in.sat_div};
    sat_ge    = (sat_trial >= {1'b0, d_in.sat_div});
    hue_trial = {d_in.hue_rem, d_in.hue_num[QB-1]};
    hue_sub   = hue_trial - {1'b0, d_in.hue_div};
    hue_ge    = (hue_trial >= {1'b0, d_in.hue_div});

    d_nxt         = d_in;
    d_nxt.sat_rem = sat_ge ? sat_sub[CB-1:0] : sat_trial[CB-1:0];
    d_nxt.sat_num = {d_in.sat_num[QB-2:0], 1'b0};
    d_nxt.sat_quo = {d_in.sat_quo[QB-2:0], sat_ge};
    d_nxt.hue_rem = hue_ge ? hue_sub[CB-1:0] : hue_trial[CB-1:0];
    d_nxt.hue_num = {d_in.hue_num[QB-2:0], 1'b0};
    d_nxt.hue_quo = {d_in.hue_quo[QB-2:0], hue_ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

@@ hw/rtl/rgbhsv_finish.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_finish
// Floor correction and sector offset for hue, achromatic override, and the
// output register.
// ----------------------------------------------------------------------------
module rgbhsv_finish (
  input  logic                   clk,
  input  logic                   en,
  input  rgbhsv_pkg::cell_data_t d_in,
  output rgbhsv_pkg::hsv_t       hsv
);

  localparam int HB = rgbhsv_pkg::HUE_BITS;
  localparam int CB = rgbhsv_pkg::CHANNEL_BITS;

  logic [HB-1:0]    quo, qadj, base;
  rgbhsv_pkg::hsv_t hsv_r, hsv_nxt;

  always_comb begin
    quo  = HB'(d_in.hue_quo);
    qadj = quo + HB'(d_in.hue_rem != '0);
    case (d_in.sector)
      rgbhsv_pkg::SEC_RED:   base = d_in.neg ? HB'(rgbhsv_pkg::HUE_FULL) : '0;
      rgbhsv_pkg::SEC_GREEN: base = HB'(2 * rgbhsv_pkg::HUE_SECTOR);
      rgbhsv_pkg::SEC_BLUE:  base = HB'(4 * rgbhsv_pkg::HUE_SECTOR);
      default:               base = '0;
    endcase

    hsv_nxt.brightness = d_in.bright;
    hsv_nxt.achromatic = d_in.achrom;
    if (d_in.achrom) begin
      hsv_nxt.hue        = '0;
      hsv_nxt.saturation = '0;
    end else begin
      // negative quotient rounds toward minus infinity
      hsv_nxt.hue        = d_in.neg ? (base - qadj) : (base + quo);
      hsv_nxt.saturation = CB'(d_in.sat_quo);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsv_r <= hsv_nxt;
    end
  end

  assign hsv = hsv_r;

endmodule

@@ hw/rtl/rgb_to_hsv_converter_core.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core
// Pipelined RGB to HSV conversion, one pixel per clock while the output is not stalled.
//
// in_data carries one RGB pixel, out_data one HSV result, both with
// valid/ready; a transfer happens when valid and ready are high together.
// Every input transfer yields exactly one output transfer, in order.
// Hue is in 1/16 degree (0..5759), saturation is 255*(max-min)/max floored,
// brightness is the largest channel, achromatic flags equal channels.
// Stages in order: two front stages, one restoring divider cell per quotient
// bit, and the output register. Throughput is one pixel per cycle while
// out_ready keeps the output moving; the divider chain is what sets the depth.
// Each stage holds its own valid bit and loads whenever it is empty or its
// successor moves, so a stalled receiver only backs up the pipeline once all
// stages are full; bubbles collapse while the output waits.
// Synchronous reset (rst_n low) empties every stage; no state is kept.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rgbhsv_pkg::pixel_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rgbhsv_pkg::hsv_t   out_data
);

  localparam int QB = rgbhsv_pkg::QUO_BITS;
  localparam int NS = QB + 3;

  logic [NS-1:0]          valid_r, valid_nxt, adv;
  rgbhsv_pkg::cell_data_t chain [QB+1];

  // per-stage load enables
  always_comb begin
    adv[NS-1] = !valid_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !valid_r[i] || adv[i+1];
    end
    for (int i = 0; i < NS; i++) begin
      if (adv[i]) begin
        valid_nxt[i] = (i == 0) ? in_valid : valid_r[(i == 0) ? 0 : i - 1];
      end else begin
        valid_nxt[i] = valid_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = valid_r[NS-1];

  rgbhsv_prep u_prep (
    .clk  (clk),
    .en_a (adv[0]),
    .en_b (adv[1]),
    .pix  (in_data),
    .seed (chain[0])
  );

  for (genvar k = 0; k < QB; k++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk   (clk),
      .en    (adv[k+2]),
      .d_in  (chain[k]),
      .d_out (chain[k+1])
    );
  end

  rgbhsv_finish u_finish (
    .clk  (clk),
    .en   (adv[NS-1]),
    .d_in (chain[QB]),
    .hsv  (out_data)
  );

endmodule
